// ===== hw/rtl/wfi_pkg.sv =====
// Shared types, constants and the cosine weight table of the wavetable interpolator.
// Used by every module of the block; no dependencies.
package wfi_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int COS_LUT_DEPTH = 256;

    localparam int POS_W  = 26;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W  = 11;
    localparam int IDX_W  = POS_W - FRAC_BITS;
    localparam int CALC_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 2;
    localparam int LUT_W  = $clog2(COS_LUT_DEPTH);
    localparam int W_W    = 17;

    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_LINEAR  = 3'd1;
    localparam logic [2:0] MODE_COSINE  = 3'd2;
    localparam logic [2:0] MODE_CUBIC   = 3'd3;
    localparam logic [2:0] MODE_HERMITE = 3'd4;

    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        MC_NONE  = 2'd0,
        MC_LERP  = 2'd1,
        MC_CUBIC = 2'd2,
        MC_HERM  = 2'd3
    } t_mclass;

    // First stage: addresses and per-request side information.
    typedef struct packed {
        logic                vld;
        logic                wr;
        logic [ADDR_W-1:0]   widx;
        logic signed [15:0]  wdata;
        logic [ADDR_W-1:0]   a0;
        logic [ADDR_W-1:0]   a1;
        logic [ADDR_W-1:0]   a2;
        logic [ADDR_W-1:0]   a3;
        logic [15:0]         t;
        logic [W_W-1:0]      w;
        t_mclass             mcls;
        logic                rerr;
    } t_s1;

    // Second stage: the four neighbor samples read from the table.
    typedef struct packed {
        logic                vld;
        logic                rerr;
        t_mclass             mcls;
        logic [15:0]         t;
        logic [W_W-1:0]      w;
        logic signed [15:0]  x0;
        logic signed [15:0]  x1;
        logic signed [15:0]  x2;
        logic signed [15:0]  x3;
    } t_s2;

    // Entry k is 65536 * sin^2(pi*k/(2N)), with the sine from a Taylor series in Q30.
    function automatic logic [W_W-1:0] half_sin_sq(int unsigned k);
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] tt;
        logic [63:0] s;
        y  = (64'd3373259426 * 64'(k)) / 64'(2 * COS_LUT_DEPTH);
        y2 = (y * y) >> 30;
        tt = (64'd1 << 30) - y2 / 64'd110;
        tt = (64'd1 << 30) - ((y2 * tt) >> 30) / 64'd72;
        tt = (64'd1 << 30) - ((y2 * tt) >> 30) / 64'd42;
        tt = (64'd1 << 30) - ((y2 * tt) >> 30) / 64'd20;
        tt = (64'd1 << 30) - ((y2 * tt) >> 30) / 64'd6;
        s  = (y * tt) >> 30;
        return W_W'((s * s + (64'd1 << 43)) >> 44);
    endfunction

    function automatic logic [COS_LUT_DEPTH*W_W-1:0] build_cos_lut();
        logic [COS_LUT_DEPTH*W_W-1:0] lut;
        lut = '0;
        for (int unsigned k = 0; k < COS_LUT_DEPTH; k++) begin
            if (2 * k <= COS_LUT_DEPTH)
                lut[k*W_W +: W_W] = half_sin_sq(k);
            else
                lut[k*W_W +: W_W] = W_W'(65536) - half_sin_sq(COS_LUT_DEPTH - k);
        end
        return lut;
    endfunction

    localparam logic [COS_LUT_DEPTH*W_W-1:0] COS_LUT = build_cos_lut();

endpackage

// ===== hw/rtl/wfi_if.sv =====
// Request and result channels of the wavetable interpolator.
// Depends on wfi_pkg for the table address width.
interface wfi_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [wfi_pkg::ADDR_W-1:0]    write_index;
    logic signed [15:0]            write_sample;
    logic [wfi_pkg::POS_W-1:0]     position;

    modport source (output valid, op, write_index, write_sample, position, input ready);
    modport sink   (input valid, op, write_index, write_sample, position, output ready);
endinterface

interface wfi_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] value;
    logic               range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink   (input valid, value, range_error, output ready);
endinterface

// ===== hw/rtl/wavetable_fractional_interpolator_top.sv =====
// Wavetable interpolator: 1024-entry sample table read at fractional positions.
// Request channel i_in carries op 0 (write a sample) or op 1 (read at position);
// result channel o_out carries one value and range_error for every op 1 request.
// Configuration: i_cfg_we writes register i_cfg_idx (0 mode, 1 table length).
// Write mode and length only while no request is in flight.
// Throughput: one request per cycle while o_out is not stalled; the table is read
// through four copies, one per neighbor sample, so all four neighbors are read at once.
// All stages move together; when o_out is stalled with a result waiting, the
// whole pipeline holds and i_in.ready drops, so nothing is lost or repeated.
// Writes and reads reach the table in request order.
// Reset clears all valid bits, sets mode to linear and length to 1024; table
// contents are undefined until written.
// Depends on wfi_pkg, wfi_if and the wfi_* stage modules.
module wavetable_fractional_interpolator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    wfi_in_if.sink                    i_in,
    wfi_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [wfi_pkg::LEN_W-1:0] i_cfg_data
);

    logic                      en;
    logic [2:0]                r_mode;
    logic [wfi_pkg::LEN_W-1:0] r_len;
    wfi_pkg::t_s1              s1;
    wfi_pkg::t_s2              s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= wfi_pkg::MODE_LINEAR;
            r_len  <= wfi_pkg::LEN_W'(wfi_pkg::TABLE_DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wfi_pkg::CFG_MODE:   r_mode <= i_cfg_data[2:0];
                wfi_pkg::CFG_LENGTH: r_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = en;

    wfi_addr u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in.valid),
        .i_op           (i_in.op),
        .i_write_index  (i_in.write_index),
        .i_write_sample (i_in.write_sample),
        .i_position     (i_in.position),
        .i_mode         (r_mode),
        .i_length       (r_len),
        .o_s1           (s1)
    );

    wfi_sample_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    wfi_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s2          (s2),
        .i_out_ready   (o_out.ready),
        .o_en          (en),
        .o_out_valid   (o_out.valid),
        .o_value       (o_out.value),
        .o_range_error (o_out.range_error)
    );

endmodule

// ===== hw/rtl/wfi_addr.sv =====
// First pipeline stage: length clamp, range check, wrapped neighbor addresses, weight.
// Depends on wfi_pkg.
module wfi_addr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_op,
    input  logic [wfi_pkg::ADDR_W-1:0]  i_write_index,
    input  logic signed [15:0]          i_write_sample,
    input  logic [wfi_pkg::POS_W-1:0]   i_position,
    input  logic [2:0]                  i_mode,
    input  logic [wfi_pkg::LEN_W-1:0]   i_length,
    output wfi_pkg::t_s1                o_s1
);

    localparam int CW = wfi_pkg::CALC_W;

    wfi_pkg::t_s1  r_s1;
    wfi_pkg::t_s1  n_s1;
    logic [CW-1:0] len;
    logic [CW-1:0] idx;
    logic [CW-1:0] i0;
    logic [CW-1:0] i2;
    logic [CW-1:0] i3;
    logic [wfi_pkg::FRAC_BITS-1:0] frac;
    logic [15:0]   t;

    always_comb begin
        len = CW'(i_length);
        if (len < CW'(2))
            len = CW'(2);
        if (len > CW'(wfi_pkg::TABLE_DEPTH))
            len = CW'(wfi_pkg::TABLE_DEPTH);

        idx  = CW'(i_position[wfi_pkg::POS_W-1:wfi_pkg::FRAC_BITS]);
        frac = i_position[wfi_pkg::FRAC_BITS-1:0];
        // Bring the fraction to Q0.16 whatever the number of fraction bits.
        t    = 16'({frac, 16'b0} >> wfi_pkg::FRAC_BITS);

        i0 = (idx == '0) ? len - CW'(1) : idx - CW'(1);
        i2 = (idx + CW'(1) >= len) ? idx + CW'(1) - len : idx + CW'(1);
        i3 = (idx + CW'(2) >= len) ? idx + CW'(2) - len : idx + CW'(2);

        n_s1       = r_s1;
        n_s1.vld   = i_valid && i_op;
        n_s1.wr    = i_valid && !i_op;
        n_s1.widx  = i_write_index;
        n_s1.wdata = i_write_sample;
        n_s1.a0    = i0[wfi_pkg::ADDR_W-1:0];
        n_s1.a1    = idx[wfi_pkg::ADDR_W-1:0];
        n_s1.a2    = i2[wfi_pkg::ADDR_W-1:0];
        n_s1.a3    = i3[wfi_pkg::ADDR_W-1:0];
        n_s1.t     = t;
        n_s1.rerr  = idx >= len;
        n_s1.w     = {1'b0, t};

        case (i_mode)
            wfi_pkg::MODE_LINEAR:  n_s1.mcls = wfi_pkg::MC_LERP;
            wfi_pkg::MODE_COSINE: begin
                n_s1.mcls = wfi_pkg::MC_LERP;
                n_s1.w    = wfi_pkg::COS_LUT[t[15 -: wfi_pkg::LUT_W] * wfi_pkg::W_W +:
                                             wfi_pkg::W_W];
            end
            wfi_pkg::MODE_CUBIC:   n_s1.mcls = wfi_pkg::MC_CUBIC;
            wfi_pkg::MODE_HERMITE: n_s1.mcls = wfi_pkg::MC_HERM;
            default:               n_s1.mcls = wfi_pkg::MC_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s1.wr  <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== hw/rtl/wfi_sample_mem.sv =====
// Sample table: four copies, each written by every write request and read at one neighbor.
// Depends on wfi_pkg for the stage types.
module wfi_sample_mem (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  wfi_pkg::t_s1  i_s1,
    output wfi_pkg::t_s2  o_s2
);

    logic signed [15:0] r_mem0 [wfi_pkg::TABLE_DEPTH];
    logic signed [15:0] r_mem1 [wfi_pkg::TABLE_DEPTH];
    logic signed [15:0] r_mem2 [wfi_pkg::TABLE_DEPTH];
    logic signed [15:0] r_mem3 [wfi_pkg::TABLE_DEPTH];
    wfi_pkg::t_s2       r_s2;

    // Reads and writes share the stage edge, so requests touch the table in order.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_s1.wr) begin
                r_mem0[i_s1.widx] <= i_s1.wdata;
                r_mem1[i_s1.widx] <= i_s1.wdata;
                r_mem2[i_s1.widx] <= i_s1.wdata;
                r_mem3[i_s1.widx] <= i_s1.wdata;
            end
            r_s2.x0   <= r_mem0[i_s1.a0];
            r_s2.x1   <= r_mem1[i_s1.a1];
            r_s2.x2   <= r_mem2[i_s1.a2];
            r_s2.x3   <= r_mem3[i_s1.a3];
            r_s2.rerr <= i_s1.rerr;
            r_s2.mcls <= i_s1.mcls;
            r_s2.t    <= i_s1.t;
            r_s2.w    <= i_s1.w;
        end
        if (!i_rst_n)
            r_s2.vld <= 1'b0;
        else if (i_en)
            r_s2.vld <= i_s1.vld;
    end

    assign o_s2 = r_s2;

endmodule

// ===== hw/rtl/wfi_datapath.sv =====
// Arithmetic stages: coefficients, two Horner products, final weighting, rounding, saturation.
// Depends on wfi_pkg; ends in the output register and produces the pipeline enable.
module wfi_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wfi_pkg::t_s2       i_s2,
    input  logic               i_out_ready,
    output logic               o_en,
    output logic               o_out_valid,
    output logic signed [15:0] o_value,
    output logic               o_range_error
);

    logic en;

    // stage 3
    logic               r3_vld, r3_rerr;
    wfi_pkg::t_mclass   r3_mcls;
    logic [15:0]        r3_t;
    logic [16:0]        r3_w;
    logic signed [15:0] r3_x1;
    logic signed [20:0] r3_ca, r3_cb, r3_cc;
    logic signed [16:0] r3_diff;
    logic signed [20:0] n3_ca, n3_cb, n3_cc;
    logic signed [20:0] x0e, x1e, x2e, x3e, c0, sd, c3, c1h;

    // stage 4
    logic               r4_vld, r4_rerr;
    wfi_pkg::t_mclass   r4_mcls;
    logic [15:0]        r4_t;
    logic [16:0]        r4_w;
    logic signed [15:0] r4_x1;
    logic signed [20:0] r4_cb, r4_cc;
    logic signed [16:0] r4_diff;
    logic signed [37:0] r4_p1;

    // stage 5
    logic               r5_vld, r5_rerr;
    wfi_pkg::t_mclass   r5_mcls;
    logic [15:0]        r5_t;
    logic [16:0]        r5_w;
    logic signed [15:0] r5_x1;
    logic signed [20:0] r5_cc;
    logic signed [16:0] r5_diff;
    logic signed [56:0] r5_p2;
    logic signed [39:0] a5;

    // stage 6
    logic               r6_vld, r6_rerr;
    wfi_pkg::t_mclass   r6_mcls;
    logic signed [15:0] r6_x1;
    logic signed [41:0] r6_m;
    logic [16:0]        r6_mw;
    logic signed [57:0] h6;
    logic signed [41:0] n6_m;
    logic [16:0]        n6_mw;

    // stage 7
    logic               r7_vld, r7_rerr;
    wfi_pkg::t_mclass   r7_mcls;
    logic signed [15:0] r7_x1;
    logic signed [59:0] r7_p3;

    // output
    logic               r_out_vld;
    logic signed [15:0] r_out_value;
    logic               r_out_rerr;
    logic signed [61:0] sum8;
    logic signed [61:0] v8;
    logic signed [15:0] n_value;

    assign en = !r_out_vld || i_out_ready;

    always_comb begin
        x0e = 21'(i_s2.x0);
        x1e = 21'(i_s2.x1);
        x2e = 21'(i_s2.x2);
        x3e = 21'(i_s2.x3);
        c0  = x3e - x2e - x0e + x1e;
        sd  = x1e - x2e;
        c1h = x2e - x0e;
        c3  = x3e - x0e + sd + sd + sd;
        case (i_s2.mcls)
            wfi_pkg::MC_CUBIC: begin
                n3_ca = c0;
                n3_cb = x0e - x1e - c0;
                n3_cc = c1h;
            end
            wfi_pkg::MC_HERM: begin
                n3_ca = c3;
                n3_cb = -(sd + sd + c1h + c3);
                n3_cc = c1h;
            end
            default: begin
                n3_ca = '0;
                n3_cb = '0;
                n3_cc = '0;
            end
        endcase
    end

    assign a5 = 40'(r4_p1) + (40'(r4_cb) <<< 16);
    assign h6 = (58'(r5_p2) + (58'(r5_cc) <<< 32) + 58'sd32768) >>> 16;

    always_comb begin
        case (r5_mcls)
            wfi_pkg::MC_LERP: begin
                n6_m  = 42'(r5_diff);
                n6_mw = r5_w;
            end
            wfi_pkg::MC_CUBIC, wfi_pkg::MC_HERM: begin
                n6_m  = h6[41:0];
                n6_mw = {1'b0, r5_t};
            end
            default: begin
                n6_m  = '0;
                n6_mw = '0;
            end
        endcase
    end

    // Round half up is a floor shift after adding half an LSB.
    always_comb begin
        case (r7_mcls)
            wfi_pkg::MC_CUBIC: begin
                sum8 = 62'(r7_p3) + (62'(r7_x1) <<< 32) + (62'sd1 <<< 31);
                v8   = sum8 >>> 32;
            end
            wfi_pkg::MC_HERM: begin
                sum8 = 62'(r7_p3) + (62'(r7_x1) <<< 33) + (62'sd1 <<< 32);
                v8   = sum8 >>> 33;
            end
            default: begin
                sum8 = 62'(r7_p3) + (62'(r7_x1) <<< 16) + (62'sd1 <<< 15);
                v8   = sum8 >>> 16;
            end
        endcase
        if (v8 > 62'sd32767)
            n_value = 16'sh7fff;
        else if (v8 < -62'sd32768)
            n_value = -16'sh8000;
        else
            n_value = v8[15:0];
        if (r7_rerr)
            n_value = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rerr <= i_s2.rerr;
            r3_mcls <= i_s2.mcls;
            r3_t    <= i_s2.t;
            r3_w    <= i_s2.w;
            r3_x1   <= i_s2.x1;
            r3_ca   <= n3_ca;
            r3_cb   <= n3_cb;
            r3_cc   <= n3_cc;
            r3_diff <= 17'(i_s2.x2) - 17'(i_s2.x1);

            r4_rerr <= r3_rerr;
            r4_mcls <= r3_mcls;
            r4_t    <= r3_t;
            r4_w    <= r3_w;
            r4_x1   <= r3_x1;
            r4_cb   <= r3_cb;
            r4_cc   <= r3_cc;
            r4_diff <= r3_diff;
            r4_p1   <= r3_ca * $signed({1'b0, r3_t});

            r5_rerr <= r4_rerr;
            r5_mcls <= r4_mcls;
            r5_t    <= r4_t;
            r5_w    <= r4_w;
            r5_x1   <= r4_x1;
            r5_cc   <= r4_cc;
            r5_diff <= r4_diff;
            r5_p2   <= a5 * $signed({1'b0, r4_t});

            r6_rerr <= r5_rerr;
            r6_mcls <= r5_mcls;
            r6_x1   <= r5_x1;
            r6_m    <= n6_m;
            r6_mw   <= n6_mw;

            r7_rerr <= r6_rerr;
            r7_mcls <= r6_mcls;
            r7_x1   <= r6_x1;
            r7_p3   <= r6_m * $signed({1'b0, r6_mw});

            r_out_value <= n_value;
            r_out_rerr  <= r7_rerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r3_vld    <= i_s2.vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r_out_vld <= r7_vld;
        end
    end

    assign o_en          = en;
    assign o_out_valid   = r_out_vld;
    assign o_value       = r_out_value;
    assign o_range_error = r_out_rerr;

endmodule

// ===== sim/wavetable_fractional_interpolator_top_test.sv =====
// Self-checking testbench of the wavetable interpolator: loads the table, then reads it
// in every mode setting and in varied lengths under random idling; checks each result.
// Depends on wfi_pkg, wfi_if and the interpolator RTL.
`timescale 1ns / 100ps

module wavetable_fractional_interpolator_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic                        op;
        logic [wfi_pkg::ADDR_W-1:0]  widx;
        logic signed [15:0]          wsample;
        logic [wfi_pkg::POS_W-1:0]   pos;
    } t_req;

    typedef struct {
        logic signed [15:0] value;
        logic               rerr;
    } t_sample_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_idx = wfi_pkg::CFG_MODE;
    logic [wfi_pkg::LEN_W-1:0] cfg_data = '0;

    wfi_in_if  req_if();
    wfi_out_if res_if();

    wavetable_fractional_interpolator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow state of the block.
    logic signed [15:0]        wave_mem [wfi_pkg::TABLE_DEPTH];
    logic [2:0]                shadow_mode;
    logic [wfi_pkg::LEN_W-1:0] shadow_len;
    longint                    weight_lut [wfi_pkg::COS_LUT_DEPTH];

    t_req        pending_reqs[$];
    t_sample_out expected_samples[$];

    logic req_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   mismatches = 0;
    int   n_writes = 0;
    int   n_reads = 0;
    int   n_range_err = 0;
    int   n_checked = 0;
    int   mode_reads [8];
    int   idle_count = 0;
    int   stall_style = 0;
    int   stall_cnt = 0;
    int   cur_len = 1024;

    initial begin
        req_if.valid = 1'b0;
        req_if.op = 1'b0;
        req_if.write_index = '0;
        req_if.write_sample = '0;
        req_if.position = '0;
        res_if.ready = 1'b0;
    end

    // Weight k of the cosine table: 65536 * sin^2(pi*k/(2N)), sine in Q30 by Taylor series.
    function automatic longint sin_sq_weight(int k);
        longint unsigned y, ysq, acc, sn;
        y   = (64'd3373259426 * 64'(k)) / 64'(2 * wfi_pkg::COS_LUT_DEPTH);
        ysq = (y * y) >> 30;
        acc = (64'd1 << 30) - ysq / 110;
        acc = (64'd1 << 30) - ((ysq * acc) >> 30) / 72;
        acc = (64'd1 << 30) - ((ysq * acc) >> 30) / 42;
        acc = (64'd1 << 30) - ((ysq * acc) >> 30) / 20;
        acc = (64'd1 << 30) - ((ysq * acc) >> 30) / 6;
        sn  = (y * acc) >> 30;
        return longint'((sn * sn + (64'd1 << 43)) >> 44);
    endfunction

    function automatic longint round_down_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic int effective_len();
        if (shadow_len < 2) return 2;
        if (shadow_len > wfi_pkg::TABLE_DEPTH) return wfi_pkg::TABLE_DEPTH;
        return int'(shadow_len);
    endfunction

    function automatic t_sample_out interpolate(logic [wfi_pkg::POS_W-1:0] pos);
        t_sample_out r;
        int len, idx, i0, i2, i3, k;
        longint t, x0, x1, x2, x3, v, h, w, c0, c1, c2, c3, s;
        len = effective_len();
        idx = int'(pos >> wfi_pkg::FRAC_BITS);
        t = longint'(pos[wfi_pkg::FRAC_BITS-1:0]);
        r.rerr = 1'b0;
        r.value = '0;
        if (idx >= len) begin
            r.rerr = 1'b1;
            return r;
        end
        i0 = (idx == 0) ? len - 1 : idx - 1;
        i2 = (idx + 1 >= len) ? idx + 1 - len : idx + 1;
        i3 = (idx + 2 >= len) ? idx + 2 - len : idx + 2;
        x0 = wave_mem[i0];
        x1 = wave_mem[idx];
        x2 = wave_mem[i2];
        x3 = wave_mem[i3];
        case (shadow_mode)
            wfi_pkg::MODE_LINEAR: v = round_down_shift(x1 * (65536 - t) + x2 * t, 16);
            wfi_pkg::MODE_COSINE: begin
                k = int'((t * wfi_pkg::COS_LUT_DEPTH) >> 16);
                w = weight_lut[k];
                v = round_down_shift(x1 * (65536 - w) + x2 * w, 16);
            end
            wfi_pkg::MODE_CUBIC: begin
                c0 = x3 - x2 - x0 + x1;
                c1 = x0 - x1 - c0;
                c2 = x2 - x0;
                h = round_down_shift((c0 * t + c1 * 65536) * t + (c2 <<< 32), 16);
                v = round_down_shift(h * t + (x1 <<< 32), 32);
            end
            wfi_pkg::MODE_HERMITE: begin
                s = x1 - x2;
                c1 = x2 - x0;
                c3 = x3 - x0 + 3 * s;
                c2 = -(2 * s + c1 + c3);
                h = round_down_shift((c3 * t + c2 * 65536) * t + (c1 <<< 32), 16);
                v = round_down_shift(h * t + (x1 <<< 33), 33);
            end
            default: v = x1;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.value = 16'(v);
        return r;
    endfunction

    // Request side: acceptance, shadow table writes and expected results.
    always @(posedge i_clk) begin
        req_taken <= req_if.valid && req_if.ready;
        if (cfg_we) begin
            if (cfg_idx == wfi_pkg::CFG_MODE) shadow_mode <= cfg_data[2:0];
            else shadow_len <= cfg_data;
        end
        if (req_if.valid && req_if.ready) begin
            if (req_if.op == 1'b0) begin
                wave_mem[req_if.write_index] <= req_if.write_sample;
                n_writes++;
            end else begin
                expected_samples.push_back(interpolate(req_if.position));
                n_reads++;
                mode_reads[shadow_mode]++;
            end
        end
    end

    // Result side.
    always @(posedge i_clk) begin
        t_sample_out exp_s;
        if (res_if.valid && res_if.ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result value=%0d range_error=%0b", $time,
                         res_if.value, res_if.range_error);
                mismatches++;
            end else begin
                exp_s = expected_samples.pop_front();
                n_checked++;
                if (exp_s.rerr) n_range_err++;
                if (res_if.value !== exp_s.value) begin
                    $display("%0t: value expected %0d actual %0d", $time, exp_s.value,
                             res_if.value);
                    mismatches++;
                end
                if (res_if.range_error !== exp_s.rerr) begin
                    $display("%0t: range_error expected %0b actual %0b", $time, exp_s.rerr,
                             res_if.range_error);
                    mismatches++;
                end
            end
        end
    end

    // Driver: bursts of requests separated by random gaps.
    always @(negedge i_clk) begin
        t_req it;
        if (i_rst_n && (!req_if.valid || req_taken)) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                req_if.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                it = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.op <= it.op;
                req_if.write_index <= it.widx;
                req_if.write_sample <= it.wsample;
                req_if.position <= it.pos;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: the stall pattern is redrawn periodically from four styles.
    always @(negedge i_clk) begin
        stall_cnt++;
        if (stall_cnt % 150 == 0) stall_style = $urandom_range(0, 3);
        case (stall_style)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            2: res_if.ready <= (stall_cnt % 4) != 0;
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (pending_reqs.size() == 0 && expected_samples.size() == 0))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_if.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        wait_idle();
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= wfi_pkg::LEN_W'(value);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == wfi_pkg::CFG_LENGTH)
            cur_len = (value < 2) ? 2 :
                      ((value > wfi_pkg::TABLE_DEPTH) ? wfi_pkg::TABLE_DEPTH : value);
    endtask

    task automatic push_write(int idx, int value);
        t_req it;
        it.op = 1'b0;
        it.widx = wfi_pkg::ADDR_W'(idx);
        it.wsample = 16'(value);
        it.pos = wfi_pkg::POS_W'($urandom);
        pending_reqs.push_back(it);
    endtask

    task automatic push_read(logic [wfi_pkg::POS_W-1:0] pos);
        t_req it;
        it.op = 1'b1;
        it.widx = wfi_pkg::ADDR_W'($urandom);
        it.wsample = 16'($urandom);
        it.pos = pos;
        pending_reqs.push_back(it);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 50) : -32768;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic logic [wfi_pkg::POS_W-1:0] rand_position();
        int idx, frac;
        case ($urandom_range(0, 9))
            0: return wfi_pkg::POS_W'($urandom);
            1: idx = cur_len - 1;
            2: idx = 0;
            3: idx = cur_len + $urandom_range(0, 3);
            default: idx = $urandom_range(0, cur_len - 1);
        endcase
        case ($urandom_range(0, 7))
            0: frac = 0;
            1: frac = 16'hFFFF;
            default: frac = $urandom_range(0, 16'hFFFF);
        endcase
        return wfi_pkg::POS_W'((longint'(idx) << wfi_pkg::FRAC_BITS) | frac);
    endfunction

    initial begin
        int phase_len;
        shadow_mode = wfi_pkg::MODE_LINEAR;
        shadow_len = wfi_pkg::LEN_W'(1024);
        for (int k = 0; k < wfi_pkg::COS_LUT_DEPTH; k++)
            weight_lut[k] = (2 * k <= wfi_pkg::COS_LUT_DEPTH) ? sin_sq_weight(k)
                          : 65536 - sin_sq_weight(wfi_pkg::COS_LUT_DEPTH - k);
        for (int m = 0; m < 8; m++) mode_reads[m] = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load every entry so that no read ever sees an unwritten one.
        for (int i = 0; i < wfi_pkg::TABLE_DEPTH; i++) push_write(i, rand_sample());
        push_write(5, 32767);
        push_write(6, -32768);
        push_write(7, 32767);

        // Directed: reset settings, edges of position and wrap.
        push_read('0);
        push_read(wfi_pkg::POS_W'((6 << wfi_pkg::FRAC_BITS) | 16'hFFFF));
        push_read(wfi_pkg::POS_W'((1023 << wfi_pkg::FRAC_BITS) | 16'h8000));
        push_read(wfi_pkg::POS_W'(1024 << wfi_pkg::FRAC_BITS));
        push_read({wfi_pkg::POS_W{1'b1}});
        push_write(100, -1);
        push_read(wfi_pkg::POS_W'((100 << wfi_pkg::FRAC_BITS) | 16'h4000));
        for (int m = 0; m < 8; m++) begin
            write_reg(wfi_pkg::CFG_MODE, m);
            push_read(wfi_pkg::POS_W'((6 << wfi_pkg::FRAC_BITS) | 16'h8000));
            push_read(wfi_pkg::POS_W'((0 << wfi_pkg::FRAC_BITS) | 16'h0001));
        end
        // Lengths below 2 and above the table depth.
        write_reg(wfi_pkg::CFG_LENGTH, 0);
        push_read(wfi_pkg::POS_W'((1 << wfi_pkg::FRAC_BITS) | 16'hC000));
        push_read(wfi_pkg::POS_W'(2 << wfi_pkg::FRAC_BITS));
        write_reg(wfi_pkg::CFG_LENGTH, 1);
        push_read(wfi_pkg::POS_W'((1 << wfi_pkg::FRAC_BITS) | 16'h2000));
        write_reg(wfi_pkg::CFG_LENGTH, 2047);
        push_read(wfi_pkg::POS_W'((1023 << wfi_pkg::FRAC_BITS) | 16'hFFFF));

        // Random phases over mode and length settings.
        for (int ph = 0; ph < 14; ph++) begin
            write_reg(wfi_pkg::CFG_MODE, (ph < 8) ? ((ph + 2) % 5) : $urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: write_reg(wfi_pkg::CFG_LENGTH, $urandom_range(0, 1));
                1: write_reg(wfi_pkg::CFG_LENGTH, 1024);
                2: write_reg(wfi_pkg::CFG_LENGTH, $urandom_range(1025, 2047));
                3: write_reg(wfi_pkg::CFG_LENGTH, $urandom_range(2, 8));
                default: write_reg(wfi_pkg::CFG_LENGTH, $urandom_range(2, 1024));
            endcase
            phase_len = 70;
            for (int n = 0; n < phase_len; n++) begin
                if ($urandom_range(0, 3) == 0)
                    push_write($urandom_range(0, wfi_pkg::TABLE_DEPTH - 1), rand_sample());
                else
                    push_read(rand_position());
                // Sender holds off until every result is back.
                if (ph == 5 && n == phase_len / 2) wait_idle();
            end
        end

        wait_idle();
        $display("Checked %0d results (%0d out of range) from %0d reads and %0d table writes.",
                 n_checked, n_range_err, n_reads, n_writes);
        $display("Reads per mode setting 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_reads[0], mode_reads[1], mode_reads[2], mode_reads[3],
                 mode_reads[4], mode_reads[5], mode_reads[6], mode_reads[7]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
